@@ rtl/utf8d_pkg.sv @@
`default_nettype none

package utf8d_pkg;

  localparam int CodeW      = 21;
  localparam int FifoDepth  = 4;
  localparam int FifoPtrW   = $clog2(FifoDepth);
  localparam int FifoCntW   = $clog2(FifoDepth + 1);

  localparam logic [CodeW-1:0] ReplChar = CodeW'(32'hFFFD);

  typedef struct packed {
    logic [1:0]       pending;
    logic [CodeW-1:0] partial;
    logic             swallow;
  } dec_state_t;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             repl;
    logic             last;
  } dec_res_t;

  typedef struct packed {
    logic             emit;
    logic [CodeW-1:0] code;
    logic             repl;
    logic [1:0]       extra;
    logic             swallow;
  } lead_t;

  function automatic lead_t decode_lead(input logic [7:0] b, input logic [1:0] after);
    lead_t            l;
    logic [1:0]       extra;
    logic [CodeW-1:0] code;
    logic             bad;
    l     = '0;
    extra = 2'd0;
    code  = '0;
    bad   = 1'b0;
    if (b[7] == 1'b0) begin
      code = CodeW'(b);
    end else if (b[7:5] == 3'b110) begin
      extra = 2'd1;
      code  = CodeW'(b[4:0]);
    end else if (b[7:4] == 4'b1110) begin
      extra = 2'd2;
      code  = CodeW'(b[3:0]);
    end else if (b[7:3] == 5'b11110) begin
      extra = 2'd3;
      code  = CodeW'(b[2:0]);
    end else begin
      bad = 1'b1;
    end
    if (b[7] == 1'b0) begin
      l.emit = 1'b1;
      l.code = code;
    end else if (bad) begin
      l.emit = 1'b1;
      l.code = ReplChar;
      l.repl = 1'b1;
    end else if (extra > after) begin
      l.emit    = 1'b1;
      l.code    = ReplChar;
      l.repl    = 1'b1;
      l.swallow = (after != 2'd0);
    end else begin
      l.extra = extra;
      l.code  = code;
    end
    return l;
  endfunction

endpackage

`default_nettype wire

@@ rtl/utf8_codepoint_decoder_unit.sv @@
// utf8_codepoint_decoder_unit
// Decodes a UTF-8 byte stream into code points. The input channel (in_valid,
// in_ready) carries one byte per transfer with in_bytes_after, the count of
// bytes still to follow in the text saturated at 3 (0 marks the last byte).
// The result channel (out_valid, out_ready) carries one code point per
// transfer; out_replaced flags U+FFFD given for malformed input and
// out_last_of_run marks the final result caused by one input byte.
// A byte is held in an input register until the queue has room, decoded in
// one pass and written, with its zero, one or two results, into a four-entry
// result queue. A result is valid once its byte has passed the input register
// and been written into the queue. Throughput is one byte per cycle while the
// queue has room; a byte leaves the input register only while the queue holds
// at most two results, so a run of double results against a receiver taking
// one per cycle holds the input back.
// When the receiver stalls the queue fills and in_ready drops after the
// input register is occupied; nothing is lost.
// Reset (rst_n low, synchronous) empties the input register and the queue
// and closes any open sequence.
`default_nettype none

module utf8_codepoint_decoder_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  in_data_byte,
  input  wire logic [1:0]                  in_bytes_after,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [utf8d_pkg::CodeW-1:0]      out_code_point,
  output logic                             out_replaced,
  output logic                             out_last_of_run
);
  import utf8d_pkg::*;

  logic                stg_valid_r;
  logic [7:0]          stg_byte_r;
  logic [1:0]          stg_after_r;
  logic                stg_adv;

  dec_state_t          st_r;
  dec_state_t          st_nxt;
  logic [1:0]          n_res;
  dec_res_t            res0;
  dec_res_t            res1;

  dec_res_t            fifo_r [FifoDepth];
  logic [FifoPtrW-1:0] wptr_r;
  logic [FifoPtrW-1:0] rptr_r;
  logic [FifoCntW-1:0] cnt_r;
  logic [FifoCntW-1:0] cnt_nxt;
  logic [FifoPtrW-1:0] wptr_p1;
  logic                pop;
  logic [1:0]          push_n;

  assign stg_adv  = stg_valid_r && (cnt_r <= FifoCntW'(FifoDepth - 2));
  assign in_ready = !stg_valid_r || stg_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_byte_r  <= in_data_byte;
      stg_after_r <= in_bytes_after;
    end
  end

  utf8d_step u_step (
    .data_byte   (stg_byte_r),
    .bytes_after (stg_after_r),
    .st          (st_r),
    .st_nxt      (st_nxt),
    .n_res       (n_res),
    .res0        (res0),
    .res1        (res1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (stg_adv) begin
      st_r <= st_nxt;
    end
  end

  // result queue
  assign pop     = out_valid && out_ready;
  assign push_n  = stg_adv ? n_res : 2'd0;
  assign wptr_p1 = wptr_r + FifoPtrW'(1);
  assign cnt_nxt = cnt_r + FifoCntW'(push_n) - FifoCntW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_r + FifoPtrW'(push_n);
      rptr_r <= rptr_r + FifoPtrW'(pop);
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_r[wptr_r] <= res0;
    end
    if (push_n == 2'd2) begin
      fifo_r[wptr_p1] <= res1;
    end
  end

  assign out_valid       = (cnt_r != '0);
  assign out_code_point  = fifo_r[rptr_r].code;
  assign out_replaced    = fifo_r[rptr_r].repl;
  assign out_last_of_run = fifo_r[rptr_r].last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FifoCntW'(FifoDepth))
    else $error("result queue overfilled");

  a_adv_room: assert property (@(posedge clk) disable iff (!rst_n)
    stg_adv |-> cnt_r <= FifoCntW'(FifoDepth - 2))
    else $error("byte decoded without room for two results");

  a_pair_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> cnt_r >= FifoCntW'(2))
    else $error("first of a result pair queued without its partner");

  a_no_pending_swallow: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.swallow |-> st_r.pending == 2'd0)
    else $error("sequence open while swallowing");

endmodule

`default_nettype wire

@@ rtl/utf8d_step.sv @@
`default_nettype none

module utf8d_step (
  input  wire logic [7:0]           data_byte,
  input  wire logic [1:0]           bytes_after,
  input  wire utf8d_pkg::dec_state_t st,
  output utf8d_pkg::dec_state_t     st_nxt,
  output logic [1:0]                n_res,
  output utf8d_pkg::dec_res_t       res0,
  output utf8d_pkg::dec_res_t       res1
);
  import utf8d_pkg::*;

  lead_t            lead;
  logic [CodeW-1:0] ext_code;

  assign lead     = decode_lead(data_byte, bytes_after);
  assign ext_code = CodeW'({st.partial, data_byte[5:0]});

  always_comb begin
    st_nxt = st;
    n_res  = 2'd0;
    res0   = '0;
    res1   = '0;
    if (st.swallow) begin
      st_nxt.swallow = (bytes_after != 2'd0);
    end else if (st.pending != 2'd0) begin
      if (data_byte[7:6] == 2'b10) begin
        st_nxt.partial = ext_code;
        st_nxt.pending = st.pending - 2'd1;
        if (st.pending == 2'd1) begin
          n_res     = 2'd1;
          res0.code = ext_code;
          res0.last = 1'b1;
        end
      end else begin
        // bad continuation, then the same byte as a lead
        res0.code      = ReplChar;
        res0.repl      = 1'b1;
        st_nxt.pending = 2'd0;
        st_nxt.partial = '0;
        if (lead.emit) begin
          n_res          = 2'd2;
          res1.code      = lead.code;
          res1.repl      = lead.repl;
          res1.last      = 1'b1;
          st_nxt.swallow = lead.swallow;
        end else begin
          n_res          = 2'd1;
          res0.last      = 1'b1;
          st_nxt.pending = lead.extra;
          st_nxt.partial = lead.code;
        end
      end
    end else begin
      if (lead.emit) begin
        n_res          = 2'd1;
        res0.code      = lead.code;
        res0.repl      = lead.repl;
        res0.last      = 1'b1;
        st_nxt.swallow = lead.swallow;
      end else begin
        st_nxt.pending = lead.extra;
        st_nxt.partial = lead.code;
      end
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/utf8_decoder_checker.sv @@
`timescale 1ns / 1ps

module utf8_decoder_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_ready,
  input  wire logic [7:0]                  in_data_byte,
  input  wire logic [1:0]                  in_bytes_after,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire logic [utf8d_pkg::CodeW-1:0] out_code_point,
  input  wire logic                        out_replaced,
  input  wire logic                        out_last_of_run,
  output int                               mismatch_count,
  output int                               open_results,
  output int                               results_checked,
  output int                               repl_checked
);
  import utf8d_pkg::*;

  dec_res_t         expected_cps[$];
  dec_res_t         step_res[2];
  int               step_n;
  logic [1:0]       seq_left;
  logic [CodeW-1:0] code_acc;
  logic             skip_to_end;

  task automatic emit_cp(input logic [CodeW-1:0] cp, input logic repl);
    step_res[step_n].code = cp;
    step_res[step_n].repl = repl;
    step_res[step_n].last = 1'b0;
    step_n++;
  endtask

  task automatic start_char(input logic [7:0] b, input logic [1:0] after);
    logic [1:0]       need;
    logic [CodeW-1:0] head;
    logic             bad;
    need = 2'd0;
    head = '0;
    bad  = 1'b0;
    if (b[7:5] == 3'b110) begin
      need = 2'd1;
      head = CodeW'(b[4:0]);
    end else if (b[7:4] == 4'b1110) begin
      need = 2'd2;
      head = CodeW'(b[3:0]);
    end else if (b[7:3] == 5'b11110) begin
      need = 2'd3;
      head = CodeW'(b[2:0]);
    end else if (b[7]) begin
      bad = 1'b1;
    end
    if (!b[7]) begin
      emit_cp(CodeW'(b), 1'b0);
    end else if (bad) begin
      emit_cp(ReplChar, 1'b1);
    end else if (need > after) begin
      skip_to_end = (after != 2'd0);
      emit_cp(ReplChar, 1'b1);
    end else begin
      seq_left = need;
      code_acc = head;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic [1:0] after);
    step_n = 0;
    if (skip_to_end) begin
      if (after == 2'd0) skip_to_end = 1'b0;
    end else if (seq_left != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        code_acc = {code_acc[CodeW-7:0], b[5:0]};
        seq_left = seq_left - 2'd1;
        if (seq_left == 2'd0) emit_cp(code_acc, 1'b0);
      end else begin
        // broken sequence, then the same byte starts afresh
        seq_left = 2'd0;
        code_acc = '0;
        emit_cp(ReplChar, 1'b1);
        start_char(b, after);
      end
    end else begin
      start_char(b, after);
    end
    for (int i = 0; i < step_n; i++) begin
      step_res[i].last = (i == step_n - 1);
      expected_cps.insert(expected_cps.size(), step_res[i]);
    end
  endtask

  task automatic check_result();
    dec_res_t want;
    if (expected_cps.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: unexpected result cp=%h repl=%b last=%b", $realtime,
                 out_code_point, out_replaced, out_last_of_run);
    end else begin
      want = expected_cps.pop_front();
      results_checked++;
      if (want.repl) repl_checked++;
      if (out_code_point !== want.code || out_replaced !== want.repl ||
          out_last_of_run !== want.last) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: mismatch cp=%h/%h repl=%b/%b last=%b/%b (got/exp)", $realtime,
                   out_code_point, want.code, out_replaced, want.repl,
                   out_last_of_run, want.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      seq_left    = 2'd0;
      code_acc    = '0;
      skip_to_end = 1'b0;
      expected_cps.delete();
    end else begin
      if (in_valid && in_ready) decode_byte(in_data_byte, in_bytes_after);
      if (out_valid && out_ready) check_result();
    end
    open_results = expected_cps.size();
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import utf8d_pkg::*;

  localparam int StreamBytes = 620;
  localparam int IdleLimit   = 2000;
  localparam int DrainCycles = 20;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       in_data_byte = 8'd0;
  logic [1:0]       in_bytes_after = 2'd0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [CodeW-1:0] out_code_point;
  logic             out_replaced;
  logic             out_last_of_run;

  int         mismatch_count;
  int         open_results;
  int         results_checked;
  int         repl_checked;
  int         bytes_sent = 0;
  int         texts_sent = 0;
  int         idle_cycles = 0;
  int         rx_wait = 0;
  bit         rx_fast = 1'b0;
  bit         out_took = 1'b0;
  bit         sender_idles = 1'b1;
  logic [7:0] text_q[$];

  utf8_codepoint_decoder_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_bytes_after  (in_bytes_after),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_code_point  (out_code_point),
    .out_replaced    (out_replaced),
    .out_last_of_run (out_last_of_run)
  );

  utf8_decoder_checker cp_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_bytes_after  (in_bytes_after),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_code_point  (out_code_point),
    .out_replaced    (out_replaced),
    .out_last_of_run (out_last_of_run),
    .mismatch_count  (mismatch_count),
    .open_results    (open_results),
    .results_checked (results_checked),
    .repl_checked    (repl_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver stalls
  always @(posedge clk) begin
    out_took <= out_valid && out_ready;
  end

  always @(negedge clk) begin
    if (out_took) begin
      rx_wait = rx_fast ? 0 : $urandom_range(0, 3);
      if ($urandom_range(0, 63) == 0) rx_fast = !rx_fast;
    end
    if (rx_wait == 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      rx_wait--;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no transfer for %0d cycles", IdleLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic [1:0] after);
    int gap;
    gap = sender_idles ? $urandom_range(0, 3) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_bytes_after <= after;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_text();
    int left;
    for (int i = 0; i < text_q.size(); i++) begin
      left = text_q.size() - 1 - i;
      send_byte(text_q[i], (left >= 3) ? 2'd3 : 2'(left));
    end
    texts_sent++;
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (open_results != 0) @(negedge clk);
  endtask

  task automatic add_cont(input int k);
    repeat (k) text_q.insert(text_q.size(), {2'b10, 6'($urandom)});
  endtask

  task automatic build_text();
    int n_chars;
    int pos;
    text_q.delete();
    n_chars = $urandom_range(1, 6);
    for (int c = 0; c < n_chars; c++) begin
      case ($urandom_range(1, 4))
        1: text_q.insert(text_q.size(), {1'b0, 7'($urandom)});
        2: begin
          text_q.insert(text_q.size(), {3'b110, 5'($urandom)});
          add_cont(1);
        end
        3: begin
          text_q.insert(text_q.size(), {4'b1110, 4'($urandom)});
          add_cont(2);
        end
        default: begin
          text_q.insert(text_q.size(), {5'b11110, 3'($urandom)});
          add_cont(3);
        end
      endcase
    end
    // damage about one text in four
    if ($urandom_range(0, 3) == 0) begin
      pos = $urandom_range(0, text_q.size() - 1);
      case ($urandom_range(0, 2))
        0: text_q[pos] = 8'($urandom);
        1: text_q.delete(pos);
        default: text_q.insert(pos, 8'($urandom));
      endcase
    end
  endtask

  initial begin
    int units;
    units = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero and the largest value of every sequence length
    text_q = '{8'h00, 8'h7F, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF,
               8'hF7, 8'hBF, 8'hBF, 8'hBF};
    send_text();
    // invalid lead bytes
    text_q = '{8'h80, 8'hF8, 8'hFF};
    send_text();
    // lead byte at the very end of the text
    text_q = '{8'hF0};
    send_text();
    // sequence running past the end, rest swallowed
    text_q = '{8'hF0, 8'h9F, 8'h98};
    send_text();
    // bad continuations, each restarting as a lead byte
    text_q = '{8'hC3, 8'h41, 8'hE2, 8'hC3, 8'hA9};
    send_text();
    wait_quiet();

    while (bytes_sent < StreamBytes) begin
      sender_idles = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 9) == 0) begin
        send_byte(8'($urandom), 2'($urandom));
      end else begin
        build_text();
        send_text();
      end
      units++;
      if (units % 50 == 0) wait_quiet();
    end
    wait_quiet();
    repeat (DrainCycles) @(posedge clk);

    $display("sent %0d bytes in %0d texts plus stray bytes", bytes_sent, texts_sent);
    $display("checked %0d code points, %0d of them replacements", results_checked,
             repl_checked);
    if (mismatch_count == 0 && open_results == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
